// File: sv/stack_language_execute_unit_defines.svh
// Assertion macros for the stack language execute unit
`ifndef STACK_LANGUAGE_EXECUTE_UNIT_DEFINES_SVH
`define STACK_LANGUAGE_EXECUTE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define SLEU_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define SLEU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/sleu_pkg.sv
// Types, codes and defaults shared by the stack language execute unit
package sleu_pkg;

  localparam int STORE_DEPTH_D = 1024;
  localparam int WORD_BITS_D   = 32;

  localparam int CMD_BITS   = 4;
  localparam int LIT_BITS   = 32;
  localparam int TOP_BITS   = 32;
  localparam int LEVEL_BITS = 11;
  localparam int FAULT_BITS = 2;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_PUSH = 4'd0,
    CMD_GET  = 4'd1,
    CMD_SET  = 4'd2,
    CMD_DUP  = 4'd3,
    CMD_DROP = 4'd4,
    CMD_SWAP = 4'd5,
    CMD_BASE = 4'd6,
    CMD_HERE = 4'd7,
    CMD_JUMP = 4'd8,
    CMD_NAME = 4'd9,
    CMD_ADD  = 4'd10,
    CMD_SUB  = 4'd11,
    CMD_MUL  = 4'd12,
    CMD_DIV  = 4'd13,
    CMD_INC  = 4'd14,
    CMD_DEC  = 4'd15
  } cmd_t;

  localparam logic [FAULT_BITS-1:0] FAULT_NONE  = 2'd0;
  localparam logic [FAULT_BITS-1:0] FAULT_DIV0  = 2'd1;
  localparam logic [FAULT_BITS-1:0] FAULT_RANGE = 2'd2;

  typedef struct packed {
    logic [CMD_BITS-1:0] command;
    logic [LIT_BITS-1:0] literal;
  } in_item_t;

  typedef struct packed {
    logic [TOP_BITS-1:0]   top_value;
    logic [LEVEL_BITS-1:0] stack_level;
    logic [FAULT_BITS-1:0] fault;
  } out_item_t;

endpackage

// File: sv/sleu_ram.sv
// Generic single-write, single-read RAM with registered read data
module sleu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: sv/stack_language_execute_unit.sv
// Stack language execute unit: one word store holds stack and memory.
// Each item reads the top words, executes, writes up to two words and reads the new top;
// jump and faulting items skip the write, mul and div iterate bit by bit, and name walks
// down to the nearest zero word, multiplying each word it walks by its index.
// One item at a time; the next is taken no sooner than the cycle after the result is delivered.
// Reset clears the pointer, then a pass over every word zeroes the store.
`include "stack_language_execute_unit_defines.svh"
module stack_language_execute_unit #(
  parameter int STORE_DEPTH = sleu_pkg::STORE_DEPTH_D,
  parameter int WORD_BITS   = sleu_pkg::WORD_BITS_D
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sleu_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output sleu_pkg::out_item_t out_data
);
  import sleu_pkg::*;

  localparam int W    = WORD_BITS;
  localparam int AW   = $clog2(STORE_DEPTH);
  localparam int SPW  = $clog2(STORE_DEPTH + 1);
  localparam int CW   = ((W > SPW) ? W : SPW) + 1;
  localparam int CNTW = $clog2(W + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);

  typedef enum logic [15:0] {
    S_CLR  = 16'h0001,
    S_IDLE = 16'h0002,
    S_RD1  = 16'h0004,
    S_RD2  = 16'h0008,
    S_RD3  = 16'h0010,
    S_EXEC = 16'h0020,
    S_MUL  = 16'h0040,
    S_DIV  = 16'h0080,
    S_NISS = 16'h0100,
    S_NCHK = 16'h0200,
    S_WR1  = 16'h0400,
    S_WR2  = 16'h0800,
    S_FIN  = 16'h1000,
    S_RES  = 16'h2000,
    S_OUT  = 16'h4000,
    S_SPARE = 16'h8000
  } state_t;

  state_t           state_r, state_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [W-1:0]     lit_r, lit_nxt;
  logic [SPW-1:0]   sp_r, sp_nxt;
  logic [W-1:0]     a_r, a_nxt;
  logic [W-1:0]     b_r, b_nxt;
  logic [AW-1:0]    wr_addr_r, wr_addr_nxt;
  logic [W-1:0]     wr_data_r, wr_data_nxt;
  logic [AW-1:0]    w2_addr_r, w2_addr_nxt;
  logic [W-1:0]     w2_data_r, w2_data_nxt;
  logic             w2_en_r, w2_en_nxt;
  logic [FAULT_BITS-1:0] fault_r, fault_nxt;
  logic [SPW-1:0]   walk_r, walk_nxt;
  logic [SPW-1:0]   idx_r, idx_nxt;
  logic [W-1:0]     acc_r, acc_nxt;
  logic [W-1:0]     prod_r, prod_nxt;
  logic [W-1:0]     mc_r, mc_nxt;
  logic [W-1:0]     mp_r, mp_nxt;
  logic [W:0]       rem_r, rem_nxt;
  logic [W-1:0]     quo_r, quo_nxt;
  logic [CNTW-1:0]  cnt_r, cnt_nxt;
  logic [AW-1:0]    clr_r, clr_nxt;
  out_item_t        out_r, out_nxt;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [W-1:0]     ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [W-1:0]     ram_rdata;

  logic [SPW-1:0]   sp_m1, sp_m2, sp_p1;
  logic             spz, sp_lt2, sp_full;
  logic [CW-1:0]    a_ext;
  logic [W:0]       div_shift;
  logic             div_ge;

  sleu_ram #(
    .WIDTH (W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign sp_m1   = sp_r - SPW'(1);
  assign sp_m2   = sp_r - SPW'(2);
  assign sp_p1   = sp_r + SPW'(1);
  assign spz     = (sp_r == '0);
  assign sp_lt2  = (sp_r < SPW'(2));
  assign sp_full = (sp_r >= SPW'(STORE_DEPTH));
  assign a_ext   = CW'(a_r);

  assign div_shift = {rem_r[W-1:0], quo_r[W-1]};
  assign div_ge    = (div_shift >= {1'b0, a_r});

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    lit_nxt     = lit_r;
    sp_nxt      = sp_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    wr_addr_nxt = wr_addr_r;
    wr_data_nxt = wr_data_r;
    w2_addr_nxt = w2_addr_r;
    w2_data_nxt = w2_data_r;
    w2_en_nxt   = w2_en_r;
    fault_nxt   = fault_r;
    walk_nxt    = walk_r;
    idx_nxt     = idx_r;
    acc_nxt     = acc_r;
    prod_nxt    = prod_r;
    mc_nxt      = mc_r;
    mp_nxt      = mp_r;
    rem_nxt     = rem_r;
    quo_nxt     = quo_r;
    cnt_nxt     = cnt_r;
    clr_nxt     = clr_r;
    out_nxt     = out_r;
    ram_we      = 1'b0;
    ram_waddr   = wr_addr_r;
    ram_wdata   = wr_data_r;
    ram_raddr   = AW'(sp_m1);

    case (state_r)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == AW'(STORE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = cmd_t'(in_data.command);
          lit_nxt   = W'(in_data.literal);
          fault_nxt = FAULT_NONE;
          w2_en_nxt = 1'b0;
          state_nxt = S_RD1;
        end
      end
      S_RD1: begin
        ram_raddr = AW'(sp_m1);
        state_nxt = S_RD2;
      end
      S_RD2: begin
        a_nxt     = ram_rdata;
        ram_raddr = AW'(sp_m2);
        state_nxt = S_RD3;
      end
      S_RD3: begin
        b_nxt     = ram_rdata;
        ram_raddr = AW'(a_r - W'(1));
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_FIN;
        case (cmd_r)
          CMD_PUSH, CMD_BASE, CMD_HERE: begin
            if (sp_full) begin
              fault_nxt = FAULT_RANGE;
            end else begin
              wr_addr_nxt = AW'(sp_r);
              wr_data_nxt = (cmd_r == CMD_PUSH) ? lit_r :
                            (cmd_r == CMD_HERE) ? W'(sp_r) : '0;
              sp_nxt      = sp_p1;
              state_nxt   = S_WR1;
            end
          end
          CMD_GET: begin
            if (spz || a_r == '0 || a_ext > DEPTH_C || sp_full) begin
              fault_nxt = FAULT_RANGE;
            end else begin
              wr_addr_nxt = AW'(sp_m1);
              wr_data_nxt = ram_rdata;
              w2_addr_nxt = AW'(sp_r);
              w2_data_nxt = a_r - W'(1);
              w2_en_nxt   = 1'b1;
              sp_nxt      = sp_p1;
              state_nxt   = S_WR1;
            end
          end
          CMD_SET: begin
            if (sp_lt2 || a_ext >= DEPTH_C) begin
              fault_nxt = FAULT_RANGE;
            end else begin
              wr_addr_nxt = AW'(a_r);
              wr_data_nxt = b_r;
              w2_addr_nxt = AW'(sp_m2);
              w2_data_nxt = a_r + W'(1);
              w2_en_nxt   = 1'b1;
              sp_nxt      = sp_m1;
              state_nxt   = S_WR1;
            end
          end
          CMD_DUP: begin
            if (spz || sp_full) begin
              fault_nxt = FAULT_RANGE;
            end else begin
              wr_addr_nxt = AW'(sp_r);
              wr_data_nxt = a_r;
              sp_nxt      = sp_p1;
              state_nxt   = S_WR1;
            end
          end
          CMD_DROP: begin
            if (spz) begin
              fault_nxt = FAULT_RANGE;
            end else begin
              wr_addr_nxt = AW'(sp_m1);
              wr_data_nxt = '0;
              sp_nxt      = sp_m1;
              state_nxt   = S_WR1;
            end
          end
          CMD_SWAP: begin
            if (sp_lt2) begin
              fault_nxt = FAULT_RANGE;
            end else begin
              wr_addr_nxt = AW'(sp_m1);
              wr_data_nxt = b_r;
              w2_addr_nxt = AW'(sp_m2);
              w2_data_nxt = a_r;
              w2_en_nxt   = 1'b1;
              state_nxt   = S_WR1;
            end
          end
          CMD_JUMP: begin
            if (spz || a_ext > DEPTH_C) begin
              fault_nxt = FAULT_RANGE;
            end else begin
              sp_nxt = SPW'(a_r);
            end
          end
          CMD_NAME: begin
            walk_nxt  = sp_r;
            acc_nxt   = '0;
            idx_nxt   = SPW'(1);
            state_nxt = S_NISS;
          end
          CMD_ADD, CMD_SUB: begin
            if (sp_lt2) begin
              fault_nxt = FAULT_RANGE;
            end else begin
              wr_addr_nxt = AW'(sp_m2);
              wr_data_nxt = (cmd_r == CMD_ADD) ? (b_r + a_r) : (b_r - a_r);
              sp_nxt      = sp_m1;
              state_nxt   = S_WR1;
            end
          end
          CMD_MUL: begin
            if (sp_lt2) begin
              fault_nxt = FAULT_RANGE;
            end else begin
              mc_nxt    = b_r;
              mp_nxt    = a_r;
              prod_nxt  = '0;
              state_nxt = S_MUL;
            end
          end
          CMD_DIV: begin
            if (sp_lt2) begin
              fault_nxt = FAULT_RANGE;
            end else if (a_r == '0) begin
              fault_nxt = FAULT_DIV0;
            end else begin
              rem_nxt   = '0;
              quo_nxt   = b_r;
              cnt_nxt   = '0;
              state_nxt = S_DIV;
            end
          end
          CMD_INC, CMD_DEC: begin
            if (spz) begin
              fault_nxt = FAULT_RANGE;
            end else begin
              wr_addr_nxt = AW'(sp_m1);
              wr_data_nxt = (cmd_r == CMD_INC) ? (a_r + W'(1)) : (a_r - W'(1));
              state_nxt   = S_WR1;
            end
          end
          default: begin
            fault_nxt = FAULT_RANGE;
          end
        endcase
      end
      S_MUL: begin
        if (mp_r == '0) begin
          if (cmd_r == CMD_NAME) begin
            acc_nxt   = acc_r + prod_r;
            idx_nxt   = idx_r + SPW'(1);
            walk_nxt  = walk_r - SPW'(1);
            state_nxt = S_NISS;
          end else begin
            wr_addr_nxt = AW'(sp_m2);
            wr_data_nxt = prod_r;
            sp_nxt      = sp_m1;
            state_nxt   = S_WR1;
          end
        end else begin
          prod_nxt = prod_r + (mp_r[0] ? mc_r : '0);
          mc_nxt   = {mc_r[W-2:0], 1'b0};
          mp_nxt   = {1'b0, mp_r[W-1:1]};
        end
      end
      S_DIV: begin
        if (cnt_r == CNTW'(W)) begin
          wr_addr_nxt = AW'(sp_m2);
          wr_data_nxt = quo_r;
          sp_nxt      = sp_m1;
          state_nxt   = S_WR1;
        end else begin
          rem_nxt = div_ge ? (div_shift - {1'b0, a_r}) : div_shift;
          quo_nxt = {quo_r[W-2:0], div_ge};
          cnt_nxt = cnt_r + CNTW'(1);
        end
      end
      S_NISS: begin
        if (walk_r == '0) begin
          fault_nxt = FAULT_RANGE;
          state_nxt = S_FIN;
        end else begin
          ram_raddr = AW'(walk_r - SPW'(1));
          state_nxt = S_NCHK;
        end
      end
      S_NCHK: begin
        if (ram_rdata == '0) begin
          wr_addr_nxt = AW'(walk_r - SPW'(1));
          wr_data_nxt = acc_r;
          sp_nxt      = walk_r;
          state_nxt   = S_WR1;
        end else begin
          mc_nxt    = ram_rdata;
          mp_nxt    = W'(idx_r);
          prod_nxt  = '0;
          state_nxt = S_MUL;
        end
      end
      S_WR1: begin
        ram_we    = 1'b1;
        ram_waddr = wr_addr_r;
        ram_wdata = wr_data_r;
        state_nxt = w2_en_r ? S_WR2 : S_FIN;
      end
      S_WR2: begin
        ram_we    = 1'b1;
        ram_waddr = w2_addr_r;
        ram_wdata = w2_data_r;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        ram_raddr = AW'(sp_m1);
        state_nxt = S_RES;
      end
      S_RES: begin
        out_nxt.top_value   = spz ? '0 : TOP_BITS'(ram_rdata);
        out_nxt.stack_level = LEVEL_BITS'(sp_r);
        out_nxt.fault       = fault_r;
        state_nxt           = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      sp_r    <= '0;
      clr_r   <= '0;
      fault_r <= FAULT_NONE;
      w2_en_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sp_r    <= sp_nxt;
      clr_r   <= clr_nxt;
      fault_r <= fault_nxt;
      w2_en_r <= w2_en_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    lit_r     <= lit_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    wr_addr_r <= wr_addr_nxt;
    wr_data_r <= wr_data_nxt;
    w2_addr_r <= w2_addr_nxt;
    w2_data_r <= w2_data_nxt;
    walk_r    <= walk_nxt;
    idx_r     <= idx_nxt;
    acc_r     <= acc_nxt;
    prod_r    <= prod_nxt;
    mc_r      <= mc_nxt;
    mp_r      <= mp_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    cnt_r     <= cnt_nxt;
    out_r     <= out_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data  = out_r;

  `SLEU_ASSERT_IMPL(a_sp_range, 1'b1, sp_r <= SPW'(STORE_DEPTH), "stack pointer beyond store")
  `SLEU_ASSERT_IMPL(a_accept_idle, in_valid && !in_stall, state_r == S_IDLE, "item taken while busy")
  `SLEU_ASSERT_IMPL(a_write_state, ram_we, state_r == S_WR1 || state_r == S_WR2 || state_r == S_CLR, "store written outside a write step")
  `SLEU_ASSERT_NEXT(a_fault_keeps_sp, state_r == S_EXEC && fault_nxt != FAULT_NONE, sp_r == $past(sp_r), "faulting item moved the stack pointer")

endmodule

// File: tb/sleu_checker.sv
// Checker for the stack language execute unit: watches both channels, predicts, compares
`timescale 1ns / 1ps
module sleu_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  sleu_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  sleu_pkg::out_item_t out_data,
  output int                  fail_count,
  output int                  pending
);
  import sleu_pkg::*;

  localparam int DEPTH = STORE_DEPTH_D;

  logic [31:0] words [DEPTH];
  logic [10:0] sp;
  out_item_t   expected_q[$];
  int          mismatches;

  assign fail_count = mismatches;

  // run one command on the shadow store; roll back on any fault
  function automatic out_item_t execute(in_item_t it);
    logic [31:0] w [DEPTH];
    int          wsp;
    logic        bad;
    logic [1:0]  flt;
    logic [31:0] a, b, p, acc, idx;
    out_item_t   r;
    w = words;
    wsp = sp;
    bad = 1'b0;
    flt = FAULT_NONE;
    a = '0; b = '0; p = '0; acc = '0; idx = 32'd1;
    case (cmd_t'(it.command))
      CMD_PUSH: if (wsp >= DEPTH) bad = 1; else begin w[wsp] = it.literal; wsp++; end
      CMD_BASE: if (wsp >= DEPTH) bad = 1; else begin w[wsp] = 0; wsp++; end
      CMD_HERE: if (wsp >= DEPTH) bad = 1; else begin w[wsp] = 32'(wsp); wsp++; end
      CMD_GET: begin
        if (wsp == 0) bad = 1;
        else begin
          wsp--; p = w[wsp];
          if (p == 0 || p > DEPTH) bad = 1;
          else begin
            a = w[p-1];
            if (wsp >= DEPTH) bad = 1; else begin w[wsp] = a; wsp++; end
            if (!bad) begin
              if (wsp >= DEPTH) bad = 1; else begin w[wsp] = p - 1; wsp++; end
            end
          end
        end
      end
      CMD_SET: begin
        if (wsp < 2) bad = 1;
        else begin
          wsp--; p = w[wsp]; wsp--; a = w[wsp];
          if (p >= DEPTH) bad = 1;
          else begin
            w[p] = a;
            w[wsp] = p + 1; wsp++;
          end
        end
      end
      CMD_DUP: if (wsp == 0 || wsp >= DEPTH) bad = 1; else begin w[wsp] = w[wsp-1]; wsp++; end
      CMD_DROP: if (wsp == 0) bad = 1; else begin wsp--; w[wsp] = 0; end
      CMD_SWAP: if (wsp < 2) bad = 1; else begin
        a = w[wsp-1]; w[wsp-1] = w[wsp-2]; w[wsp-2] = a;
      end
      CMD_JUMP: if (wsp == 0) bad = 1; else begin
        wsp--; p = w[wsp];
        if (p > DEPTH) bad = 1; else wsp = p;
      end
      CMD_NAME: begin
        while (!bad && wsp > 0 && w[wsp-1] != 0) begin
          wsp--; acc = acc + w[wsp] * idx; idx++;
        end
        if (wsp == 0) bad = 1;
        if (!bad) begin
          wsp--; w[wsp] = 0;
          w[wsp] = acc; wsp++;
        end
      end
      CMD_INC, CMD_DEC: if (wsp == 0) bad = 1; else
        w[wsp-1] = (it.command == CMD_INC) ? w[wsp-1] + 1 : w[wsp-1] - 1;
      default: begin
        if (wsp < 2) bad = 1;
        else begin
          a = w[wsp-1]; b = w[wsp-2]; wsp -= 2;
          case (cmd_t'(it.command))
            CMD_ADD: w[wsp] = b + a;
            CMD_SUB: w[wsp] = b - a;
            CMD_MUL: w[wsp] = b * a;
            default: if (a == 0) flt = FAULT_DIV0; else w[wsp] = b / a;
          endcase
          wsp++;
        end
      end
    endcase
    if (bad) flt = FAULT_RANGE;
    if (flt == FAULT_NONE) begin
      words = w;
      sp = 11'(wsp);
    end
    r.top_value   = (sp == 0) ? 32'd0 : words[sp-1];
    r.stack_level = sp;
    r.fault       = flt;
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t e;
    if (!rst_n) begin
      foreach (words[k]) words[k] = '0;
      sp = '0;
      expected_q.delete();
      mismatches <= 0;
      pending <= 0;
    end else begin
      if (in_valid && !in_stall) expected_q.push_back(execute(in_data));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected item: %p", out_data);
        end else begin
          e = expected_q.pop_front();
          if (e !== out_data) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: expected top %h level %0d fault %0d, got top %h level %0d fault %0d",
                       e.top_value, e.stack_level, e.fault,
                       out_data.top_value, out_data.stack_level, out_data.fault);
          end
        end
      end
      pending <= expected_q.size();
    end
  end

endmodule

// File: tb/tb_top.sv
// Top of the stack language execute unit testbench: stimulus and verdict
`timescale 1ns / 1ps
module tb_top;
  import sleu_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  int        fail_count;
  int        pending;
  logic      calm;
  int        hold_reqs;
  int        sent;

  stack_language_execute_unit i_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data
  );

  sleu_checker i_checker (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .fail_count, .pending
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("Some tests failed");
    $finish;
  end

  // receiver: random stall, a quiet stretch, and one long hold-off
  initial begin
    int hold_seen;
    int hold_cycles;
    hold_seen = 0;
    hold_cycles = 0;
    out_stall = 1'b1;
    forever begin
      @(posedge clk);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_cycles = 300;
      end
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else
        out_stall <= calm ? 1'b0 : ($urandom_range(99) < 32);
    end
  end

  task automatic offer(cmd_t c, logic [31:0] lit);
    in_valid <= 1'b1;
    in_data  <= {c, lit};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    if (!calm) begin
      while ($urandom_range(99) < 32) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(1025);
      3: return $urandom_range(8);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    cmd_t c;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    calm = 1'b0;
    hold_reqs = 0;
    sent = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    // directed: empty-stack faults, extremes, every command
    offer(CMD_DROP, 0); offer(CMD_NAME, 0); offer(CMD_GET, 0); offer(CMD_SWAP, 0);
    offer(CMD_PUSH, 32'hFFFF_FFFF); offer(CMD_INC, 0); offer(CMD_DEC, 0);
    offer(CMD_PUSH, 0); offer(CMD_DIV, 0);
    offer(CMD_PUSH, 7); offer(CMD_PUSH, 3); offer(CMD_SUB, 0);
    offer(CMD_PUSH, 5); offer(CMD_MUL, 0); offer(CMD_PUSH, 3); offer(CMD_DIV, 0);
    offer(CMD_DUP, 0); offer(CMD_PUSH, 1); offer(CMD_SET, 0); offer(CMD_GET, 0);
    offer(CMD_BASE, 0); offer(CMD_PUSH, 9); offer(CMD_PUSH, 4); offer(CMD_NAME, 0);
    offer(CMD_HERE, 0); offer(CMD_JUMP, 0); offer(CMD_PUSH, 1025); offer(CMD_JUMP, 0);
    offer(CMD_PUSH, 1024); offer(CMD_SET, 0); offer(CMD_ADD, 0);
    drain();
    // fill to the top, overflow, then empty again
    offer(CMD_PUSH, 1024); offer(CMD_JUMP, 0); offer(CMD_PUSH, 1); offer(CMD_DUP, 0);
    offer(CMD_HERE, 0); offer(CMD_BASE, 0); offer(CMD_NAME, 0);
    offer(CMD_BASE, 0); offer(CMD_JUMP, 0);
    drain();
    // receiver holds off while sender keeps offering
    hold_reqs = hold_reqs + 1;
    for (int k = 0; k < 12; k++) offer(CMD_PUSH, $urandom);
    drain();
    for (int k = 0; k < 720; k++) begin
      calm = (k >= 400 && k < 500);
      if ($urandom_range(99) < 45) offer(CMD_PUSH, rand_word());
      else if ($urandom_range(99) < 10) begin
        // well-formed name list
        offer(CMD_BASE, 0);
        repeat ($urandom_range(4)) offer(CMD_PUSH, $urandom | 32'd1);
        offer(CMD_NAME, 0);
      end else begin
        c = cmd_t'($urandom_range(15));
        offer(c, $urandom);
      end
      if (k % 150 == 149) begin
        offer(CMD_BASE, 0);
        offer(CMD_JUMP, 0);
      end
    end
    calm = 1'b0;
    drain();
    repeat (100) @(posedge clk);
    $display("Ran %0d items: all commands, faults, stack extremes, name walks.", sent);
    $display("Receiver hold-off and sender drain pauses exercised.");
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+sv
sv/sleu_pkg.sv
sv/sleu_ram.sv
sv/stack_language_execute_unit.sv
tb/sleu_checker.sv
tb/tb_top.sv
